// ===== hw/rtl/srss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range scan supervisor package
// Command, phase, status and register index codes, register reset values and
// fixed field widths and limits shared by the supervisor modules.
// ----------------------------------------------------------------------------
package srss_pkg;

    localparam int STEP_W   = 10;
    localparam int TOL_W    = 8;
    localparam int ELIM_W   = 10;
    localparam int LLIM_W   = 10;
    localparam int LOAD_W   = 11;
    localparam int CNT_W    = 6;
    localparam int LINK_W   = 3;
    localparam int STRAIN_W = 3;

    localparam logic [CNT_W-1:0]    MOVE_THRESHOLD  = 6'd3;
    localparam logic [LINK_W-1:0]   LINK_FAIL_LIMIT = 3'd5;
    localparam logic [STRAIN_W-1:0] STRAIN_LIMIT    = 3'd5;
    localparam logic [CNT_W-1:0]    MIN_POLL_INDEX  = 6'd2;

    localparam logic [STEP_W-1:0] RST_STEP_SIZE   = 10'd50;
    localparam logic [TOL_W-1:0]  RST_ARRIVE_TOL  = 8'd10;
    localparam logic [ELIM_W-1:0] RST_EXCESS_ERR  = 10'd80;
    localparam logic [LLIM_W-1:0] RST_LOAD_LIMIT  = 10'd300;
    localparam logic [CNT_W-1:0]  RST_STUCK_LIMIT = 6'd8;
    localparam logic [CNT_W-1:0]  RST_POLL_LIMIT  = 6'd40;

    typedef enum logic [1:0] {
        CMD_PLAN = 2'd0,
        CMD_POLL = 2'd1,
        CMD_STOP = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PLAN = 2'd1,
        PH_MOVE = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        ST_WAIT      = 4'd0,
        ST_MOVE      = 4'd1,
        ST_REVERSED  = 4'd2,
        ST_DONE      = 4'd3,
        ST_ARRIVED   = 4'd4,
        ST_BLOCKED   = 4'd5,
        ST_TIMEOUT   = 4'd6,
        ST_LINK_FAIL = 4'd7,
        ST_EXCESS    = 4'd8,
        ST_READ_FAIL = 4'd9,
        ST_STOPPED   = 4'd10,
        ST_IGNORED   = 4'd11
    } t_status;

    typedef enum logic [2:0] {
        CFG_LOWER_LIMIT = 3'd0,
        CFG_UPPER_LIMIT = 3'd1,
        CFG_STEP_SIZE   = 3'd2,
        CFG_ARRIVE_TOL  = 3'd3,
        CFG_EXCESS_ERR  = 3'd4,
        CFG_LOAD_LIMIT  = 3'd5,
        CFG_STUCK_LIMIT = 3'd6,
        CFG_POLL_LIMIT  = 3'd7
    } t_cfg_idx;

    // registers whose widths do not follow the position width
    typedef struct packed {
        logic [STEP_W-1:0] step_size;
        logic [TOL_W-1:0]  arrive_tol;
        logic [ELIM_W-1:0] excess_err;
        logic [LLIM_W-1:0] load_limit;
        logic [CNT_W-1:0]  stuck_limit;
        logic [CNT_W-1:0]  poll_limit;
    } t_cfg_misc;

endpackage
`default_nettype wire

// ===== hw/rtl/srss_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range scan supervisor configuration registers
// Write-only register file; each register keeps the low bits of the data.
// ----------------------------------------------------------------------------
module srss_cfg
    import srss_pkg::*;
#(
    parameter int POSITION_BITS = 12,
    parameter int DATA_BITS     = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [2:0]               i_idx,
    input  wire logic [DATA_BITS-1:0]     i_wdata,
    output logic      [POSITION_BITS-1:0] o_lower_limit,
    output logic      [POSITION_BITS-1:0] o_upper_limit,
    output t_cfg_misc                     o_misc
);

    logic [POSITION_BITS-1:0] r_lower_limit;
    logic [POSITION_BITS-1:0] r_upper_limit;
    t_cfg_misc                r_misc;
    t_cfg_idx                 idx;

    assign idx = t_cfg_idx'(i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_limit      <= '0;
            r_upper_limit      <= '1;
            r_misc.step_size   <= RST_STEP_SIZE;
            r_misc.arrive_tol  <= RST_ARRIVE_TOL;
            r_misc.excess_err  <= RST_EXCESS_ERR;
            r_misc.load_limit  <= RST_LOAD_LIMIT;
            r_misc.stuck_limit <= RST_STUCK_LIMIT;
            r_misc.poll_limit  <= RST_POLL_LIMIT;
        end else if (i_we) begin
            unique case (idx)
                CFG_LOWER_LIMIT: r_lower_limit      <= i_wdata[POSITION_BITS-1:0];
                CFG_UPPER_LIMIT: r_upper_limit      <= i_wdata[POSITION_BITS-1:0];
                CFG_STEP_SIZE:   r_misc.step_size   <= i_wdata[STEP_W-1:0];
                CFG_ARRIVE_TOL:  r_misc.arrive_tol  <= i_wdata[TOL_W-1:0];
                CFG_EXCESS_ERR:  r_misc.excess_err  <= i_wdata[ELIM_W-1:0];
                CFG_LOAD_LIMIT:  r_misc.load_limit  <= i_wdata[LLIM_W-1:0];
                CFG_STUCK_LIMIT: r_misc.stuck_limit <= i_wdata[CNT_W-1:0];
                CFG_POLL_LIMIT:  r_misc.poll_limit  <= i_wdata[CNT_W-1:0];
                default:         r_misc             <= r_misc;
            endcase
        end
    end

    assign o_lower_limit = r_lower_limit;
    assign o_upper_limit = r_upper_limit;
    assign o_misc        = r_misc;

endmodule
`default_nettype wire

// ===== hw/rtl/srss_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range scan supervisor decision core
// Scan state registers and the combinational decision for one registered beat:
// plan, poll and stop handling, counters and the result fields.
// ----------------------------------------------------------------------------
module srss_core
    import srss_pkg::*;
#(
    parameter int POSITION_BITS = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_fire,
    input  wire t_cmd                     i_cmd,
    input  wire logic                     i_read_ok,
    input  wire logic [POSITION_BITS-1:0] i_position,
    input  wire logic                     i_load_ok,
    input  wire logic [LOAD_W-1:0]        i_load,
    input  wire logic [POSITION_BITS-1:0] i_lower_limit,
    input  wire logic [POSITION_BITS-1:0] i_upper_limit,
    input  wire t_cfg_misc                i_misc,
    output t_status                       o_status,
    output logic      [POSITION_BITS-1:0] o_move_target,
    output logic      [POSITION_BITS-1:0] o_position_error,
    output logic                          o_scan_direction
);

    localparam int P  = POSITION_BITS;
    localparam int MW = ((P > ELIM_W) ? P : ELIM_W) + 1;  // unsigned compare width
    localparam int SW = ((P > STEP_W) ? P : STEP_W) + 3;  // signed target width

    t_phase                r_phase, n_phase;
    logic                  r_going_down, n_going_down;
    logic                  r_went_back, n_went_back;
    logic [P-1:0]          r_target, n_target;
    logic [P-1:0]          r_prev, n_prev;
    logic [P-1:0]          r_err, n_err;
    logic [CNT_W-1:0]      r_poll_idx, n_poll_idx;
    logic [LINK_W-1:0]     r_link, n_link;
    logic [CNT_W-1:0]      r_still, n_still;
    logic [STRAIN_W-1:0]   r_strain, n_strain;

    logic                  gd_eff, wb_eff;
    logic signed [SW-1:0]  s_cur, s_step, s_upper, s_lower, s_max;
    logic signed [SW-1:0]  s_plan_tgt, s_back;
    logic [P-1:0]          back_pos;
    logic [P-1:0]          err, delta;
    logic [MW-1:0]         err_x, tol_x, elim_x;
    logic                  still, strained, blocked;
    logic [LOAD_W-1:0]     abs_load;
    logic [CNT_W-1:0]      still_next, poll_inc;
    logic [STRAIN_W-1:0]   strain_next;
    logic [LINK_W-1:0]     link_inc;
    t_status               status;
    logic [P-1:0]          move_target;

    // a plan beat outside a scan starts a fresh one
    assign gd_eff = (r_phase == PH_PLAN) ? r_going_down : 1'b0;
    assign wb_eff = (r_phase == PH_PLAN) ? r_went_back  : 1'b0;

    assign s_cur   = $signed({{(SW-P){1'b0}}, i_position});
    assign s_step  = $signed({{(SW-STEP_W){1'b0}}, i_misc.step_size});
    assign s_upper = $signed({{(SW-P){1'b0}}, i_upper_limit});
    assign s_lower = $signed({{(SW-P){1'b0}}, i_lower_limit});
    assign s_max   = $signed({{(SW-P){1'b0}}, {P{1'b1}}});

    assign s_plan_tgt = gd_eff ? (s_cur - s_step) : (s_cur + s_step);

    // backoff: two steps against the scan direction, clamped to the position range
    assign s_back = r_going_down ? (s_cur + (s_step <<< 1)) : (s_cur - (s_step <<< 1));
    always_comb begin
        if (s_back < 0) begin
            back_pos = '0;
        end else if (s_back > s_max) begin
            back_pos = '1;
        end else begin
            back_pos = s_back[P-1:0];
        end
    end

    assign err   = (i_position > r_target) ? (i_position - r_target) : (r_target - i_position);
    assign delta = (i_position > r_prev)   ? (i_position - r_prev)   : (r_prev - i_position);
    assign err_x  = {{(MW-P){1'b0}}, err};
    assign tol_x  = {{(MW-TOL_W){1'b0}}, i_misc.arrive_tol};
    assign elim_x = {{(MW-ELIM_W){1'b0}}, i_misc.excess_err};

    assign still = (delta < P'(MOVE_THRESHOLD));

    // magnitude of the load; the most negative value gives 1024, which fits
    assign abs_load = !i_load_ok ? '0 : (i_load[LOAD_W-1] ? (~i_load + 1'b1) : i_load);

    assign strained = (abs_load > {1'b0, i_misc.load_limit}) && still && (err_x > elim_x);

    assign still_next  = !still ? '0 : ((r_still == '1) ? r_still : r_still + 1'b1);
    assign strain_next = !strained ? '0 : ((r_strain == '1) ? r_strain : r_strain + 1'b1);

    assign blocked = (r_poll_idx > MIN_POLL_INDEX)
                  && ((still_next >= i_misc.stuck_limit) || (strain_next >= STRAIN_LIMIT));

    assign poll_inc = r_poll_idx + 1'b1;
    assign link_inc = r_link + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_going_down = r_going_down;
        n_went_back  = r_went_back;
        n_target     = r_target;
        n_prev       = r_prev;
        n_err        = r_err;
        n_poll_idx   = r_poll_idx;
        n_link       = r_link;
        n_still      = r_still;
        n_strain     = r_strain;
        status       = ST_IGNORED;
        move_target  = '0;

        unique case (i_cmd)
            CMD_PLAN: begin
                if (r_phase != PH_MOVE) begin
                    n_going_down = gd_eff;
                    n_went_back  = wb_eff;
                    if (!i_read_ok) begin
                        n_phase = PH_IDLE;
                        status  = ST_READ_FAIL;
                    end else if (s_plan_tgt >= s_upper) begin
                        n_going_down = 1'b1;
                        n_went_back  = 1'b1;
                        n_phase      = PH_PLAN;
                        status       = ST_REVERSED;
                    end else if (s_plan_tgt <= s_lower) begin
                        if (wb_eff) begin
                            n_phase = PH_IDLE;
                            status  = ST_DONE;
                        end else begin
                            n_going_down = 1'b0;
                            n_phase      = PH_PLAN;
                            status       = ST_WAIT;
                        end
                    end else begin
                        n_target    = s_plan_tgt[P-1:0];
                        n_prev      = i_position;
                        n_poll_idx  = '0;
                        n_link      = '0;
                        n_still     = '0;
                        n_strain    = '0;
                        n_phase     = PH_MOVE;
                        status      = ST_MOVE;
                        move_target = s_plan_tgt[P-1:0];
                    end
                end
            end
            CMD_POLL: begin
                if (r_phase == PH_MOVE) begin
                    if (!i_read_ok) begin
                        n_link = link_inc;
                        if (link_inc >= LINK_FAIL_LIMIT) begin
                            n_phase = PH_IDLE;
                            status  = ST_LINK_FAIL;
                        end else begin
                            n_poll_idx = poll_inc;
                            if (poll_inc >= i_misc.poll_limit) begin
                                n_phase = PH_IDLE;
                                status  = ST_TIMEOUT;
                            end else begin
                                status  = ST_WAIT;
                            end
                        end
                    end else begin
                        n_link = '0;
                        n_err  = err;
                        if (err_x <= tol_x) begin
                            n_phase = PH_PLAN;
                            status  = (err_x > elim_x) ? ST_EXCESS : ST_ARRIVED;
                        end else begin
                            n_prev   = i_position;
                            n_still  = still_next;
                            n_strain = strain_next;
                            if (blocked) begin
                                n_phase     = PH_IDLE;
                                status      = ST_BLOCKED;
                                move_target = back_pos;
                            end else begin
                                n_poll_idx = poll_inc;
                                if (poll_inc >= i_misc.poll_limit) begin
                                    n_phase = PH_IDLE;
                                    status  = ST_TIMEOUT;
                                end else begin
                                    status  = ST_WAIT;
                                end
                            end
                        end
                    end
                end
            end
            CMD_STOP: begin
                n_phase = PH_IDLE;
                status  = ST_STOPPED;
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_going_down <= 1'b0;
            r_went_back  <= 1'b0;
            r_target     <= '0;
            r_prev       <= '0;
            r_err        <= '0;
            r_poll_idx   <= '0;
            r_link       <= '0;
            r_still      <= '0;
            r_strain     <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_going_down <= n_going_down;
            r_went_back  <= n_went_back;
            r_target     <= n_target;
            r_prev       <= n_prev;
            r_err        <= n_err;
            r_poll_idx   <= n_poll_idx;
            r_link       <= n_link;
            r_still      <= n_still;
            r_strain     <= n_strain;
        end
    end

    assign o_status         = status;
    assign o_move_target    = move_target;
    assign o_position_error = n_err;
    assign o_scan_direction = n_going_down;

    a_move_enters_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && status == ST_MOVE |=> r_phase == PH_MOVE && r_target == $past(move_target))
        else $error("move issued without entering move phase");

    a_scan_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (status == ST_BLOCKED || status == ST_TIMEOUT || status == ST_LINK_FAIL
                   || status == ST_STOPPED || status == ST_DONE || status == ST_READ_FAIL)
        |=> r_phase == PH_IDLE)
        else $error("scan end did not return to idle");

    a_reverse_sets_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && status == ST_REVERSED |=> r_going_down && r_went_back && r_phase == PH_PLAN)
        else $error("reversal did not set direction");

    a_hold_without_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_phase) && $stable(r_target) && $stable(r_poll_idx))
        else $error("scan state changed without a beat");

endmodule
`default_nettype wire

// ===== hw/rtl/servo_range_scan_supervisor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo range scan supervisor
// Drives a back-and-forth range scan of one joint: plans scan moves, checks
// poll samples for arrival, stall, timeout and link faults, handles stop.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   in       | i_in_valid / o_in_stall| i_cmd i_read_ok i_position i_load_ok
//            |                        | i_load
//   out      | o_out_valid/i_out_stall| o_status o_move_target o_position_error
//            |                        | o_scan_direction
//   cfg      | i_cfg_we               | i_cfg_idx i_cfg_wdata
//
// One beat per cycle sustained while the output is not stalled; a beat passes
// the input register, then decision logic into the result register.
// An empty input register still takes a beat while a result waits on a stalled output.
// Reset is synchronous: scan idle, registers at their documented defaults.
// Output stall backs up through the input register to o_in_stall.
// ----------------------------------------------------------------------------
module servo_range_scan_supervisor
    import srss_pkg::*;
#(
    parameter  int POSITION_BITS = 12,
    localparam int CFG_BITS      = (POSITION_BITS > ELIM_W) ? POSITION_BITS : ELIM_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_cmd,
    input  wire logic                     i_read_ok,
    input  wire logic [POSITION_BITS-1:0] i_position,
    input  wire logic                     i_load_ok,
    input  wire logic signed [LOAD_W-1:0] i_load,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic      [3:0]               o_status,
    output logic      [POSITION_BITS-1:0] o_move_target,
    output logic      [POSITION_BITS-1:0] o_position_error,
    output logic                          o_scan_direction,
    input  wire logic                     i_cfg_we,
    input  wire logic [2:0]               i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]      i_cfg_wdata
);

    logic                     r_in_valid;
    t_cmd                     r_cmd;
    logic                     r_read_ok;
    logic [POSITION_BITS-1:0] r_position;
    logic                     r_load_ok;
    logic [LOAD_W-1:0]        r_load;

    logic                     r_out_valid;
    t_status                  r_status;
    logic [POSITION_BITS-1:0] r_move_target;
    logic [POSITION_BITS-1:0] r_position_error;
    logic                     r_scan_direction;

    logic                     advance;
    logic                     fire;
    logic                     in_stall;

    logic [POSITION_BITS-1:0] lower_limit;
    logic [POSITION_BITS-1:0] upper_limit;
    t_cfg_misc                cfg_misc;

    t_status                  core_status;
    logic [POSITION_BITS-1:0] core_move_target;
    logic [POSITION_BITS-1:0] core_position_error;
    logic                     core_scan_direction;

    assign advance  = !r_out_valid || !i_out_stall;
    assign fire     = r_in_valid && advance;
    assign in_stall = r_in_valid && !advance;

    srss_cfg #(
        .POSITION_BITS (POSITION_BITS),
        .DATA_BITS     (CFG_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_we          (i_cfg_we),
        .i_idx         (i_cfg_idx),
        .i_wdata       (i_cfg_wdata),
        .o_lower_limit (lower_limit),
        .o_upper_limit (upper_limit),
        .o_misc        (cfg_misc)
    );

    srss_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_cmd            (r_cmd),
        .i_read_ok        (r_read_ok),
        .i_position       (r_position),
        .i_load_ok        (r_load_ok),
        .i_load           (r_load),
        .i_lower_limit    (lower_limit),
        .i_upper_limit    (upper_limit),
        .i_misc           (cfg_misc),
        .o_status         (core_status),
        .o_move_target    (core_move_target),
        .o_position_error (core_position_error),
        .o_scan_direction (core_scan_direction)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !in_stall) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_read_ok  <= i_read_ok;
            r_position <= i_position;
            r_load_ok  <= i_load_ok;
            r_load     <= i_load;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status         <= core_status;
            r_move_target    <= core_move_target;
            r_position_error <= core_position_error;
            r_scan_direction <= core_scan_direction;
        end
    end

    assign o_in_stall       = in_stall;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_move_target    = r_move_target;
    assign o_position_error = r_position_error;
    assign o_scan_direction = r_scan_direction;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid && r_status == $past(core_status))
        else $error("processed beat did not reach the result register");

    a_target_only_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_MOVE && r_status != ST_BLOCKED |-> r_move_target == '0)
        else $error("move target set on a result without a move");

endmodule
`default_nettype wire
